@@ hw/rtl/assert_macros.svh @@
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold
`define HIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property must never hold
`define HIT_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

@@ hw/rtl/hit_pkg.sv @@
package hit_pkg;

  localparam int unsigned HotendCount = 4;
  localparam int unsigned NumLanes    = 4;
  localparam int unsigned TempW       = 15;
  localparam int unsigned TargetW     = 10;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned SpanW       = 20;
  localparam int unsigned CountW      = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 15;
  localparam int unsigned InDataW     = 176;
  localparam int unsigned OutDataW    = 56;

  localparam logic [SpanW-1:0]   MsPerSecond  = SpanW'(1000);
  localparam logic [TempW-1:0]   TriggerReset = TempW'(1200);
  localparam logic [CountW-1:0]  HotendsReset = CountW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeout    = 3'd0,
    CfgTrigger    = 3'd1,
    CfgIdleNozzle = 3'd2,
    CfgIdleBed    = 3'd3,
    CfgHotends    = 3'd4,
    CfgBedPresent = 3'd5
  } cfg_reg_e;

  // last field in the lowest bits
  typedef struct packed {
    logic                              pad;
    logic [TimeW-1:0]                  extruder_position;
    logic [TargetW-1:0]                bed_target_now;
    logic [NumLanes-1:0][TargetW-1:0]  target;
    logic [NumLanes-1:0][TempW-1:0]    temp;
    logic                              busy_req;
    logic [TimeW-1:0]                  now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]                        pad;
    logic                              armed;
    logic [TargetW-1:0]                new_bed_target;
    logic [NumLanes-1:0][TargetW-1:0]  new_target;
    logic                              idle_fired;
  } out_beat_t;

  typedef struct packed {
    logic               hot;
    logic [TargetW-1:0] lowered;
  } lane_out_t;

  typedef struct packed {
    logic fire;
    logic armed;
  } timer_stat_t;

endpackage

@@ hw/rtl/hit_lane.sv @@
module hit_lane
  import hit_pkg::*;
(
  input  logic signed [TempW-1:0] temp_i,
  input  logic [TargetW-1:0]      target_i,
  input  logic signed [TempW-1:0] trigger_i,
  input  logic [TargetW-1:0]      idle_target_i,
  input  logic                    en_i,
  output lane_out_t               lane_o
);

  assign lane_o.hot     = en_i && (temp_i >= trigger_i);
  // only ever lowers the target
  assign lane_o.lowered = (en_i && (idle_target_i < target_i)) ? idle_target_i : target_i;

endmodule

@@ hw/rtl/hit_timer.sv @@
`include "assert_macros.svh"

module hit_timer
  import hit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [TimeW-1:0]    now_i,
  input  logic                busy_i,
  input  logic [TimeW-1:0]    pos_i,
  input  logic [SpanW-1:0]    span_i,
  input  logic [NumLanes-1:0] lane_hot_i,
  output timer_stat_t         stat_o
);

  logic [TimeW-1:0] deadline_q, deadline_d;
  logic             valid_q, valid_d;
  logic [TimeW-1:0] last_pos_q;
  logic [TimeW-1:0] new_deadline;
  logic [TimeW-1:0] elapsed;
  logic             hot, moved, fire;

  assign hot          = !busy_i && (span_i != '0) && (|lane_hot_i);
  assign moved        = pos_i != last_pos_q;
  assign new_deadline = now_i + TimeW'(span_i);
  assign elapsed      = now_i - deadline_q;

  // a deadline set on this beat is span ahead and cannot have passed yet
  assign fire = hot && valid_q && !moved && !elapsed[TimeW-1];

  always_comb begin
    deadline_d = deadline_q;
    valid_d    = hot && !fire;
    if (hot && (!valid_q || moved)) begin
      deadline_d = new_deadline;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      valid_q    <= 1'b0;
      last_pos_q <= '0;
    end else if (accept_i) begin
      deadline_q <= deadline_d;
      valid_q    <= valid_d;
      last_pos_q <= pos_i;
    end
  end

  assign stat_o.fire  = fire;
  assign stat_o.armed = valid_d;

  `HIT_ASSERT(a_fire_disarms, (rst_ni && accept_i && fire) |=> !valid_q, "fired but still armed")
  `HIT_ASSERT(a_motion_rearms, (rst_ni && accept_i && hot && moved) |=> (valid_q && deadline_q == $past(new_deadline)), "motion did not push deadline")
  `HIT_ASSERT_NEVER(a_fire_cold, fire && !valid_q, "fire without armed deadline")

endmodule

@@ hw/rtl/hit_skid.sv @@
`include "assert_macros.svh"

module hit_skid
  import hit_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  out_beat_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic      out_valid_q, skid_valid_q;
  out_beat_t out_q, skid_q;
  logic      in_acc, out_acc;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_acc) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc && skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc && (out_acc || !out_valid_q)) begin
      out_q <= in_data_i;
    end
    if (in_acc && out_valid_q && !out_acc) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HIT_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid beat without output beat")
  `HIT_ASSERT(a_skid_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i), "skid filled without stall")

endmodule

@@ hw/rtl/hotend_idle_timeout.sv @@
// Hotend idle supervisor: one check beat in, one result beat out. A new beat may
// be taken in every cycle while the output buffer has room; the result is registered
// in a two-beat output buffer, so the input stalls only when two results wait
// downstream. Four temperature lanes compare against the trigger in parallel and
// the deadline logic merges them; the deadline update and its wrap-safe elapsed
// test close in the cycle in which the beat is accepted. Registers are written over
// the cfg port, which is always ready; write them only while no check is in flight.
module hotend_idle_timeout
  import hit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // now_ms, busy_req, temp_0..temp_3, target_0..target_3, bed_target_now,
  // extruder_position, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // idle_fired, new_target_0..new_target_3, new_bed_target, armed, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [SpanW-1:0]        span_q;
  logic signed [TempW-1:0] trigger_q;
  logic [TargetW-1:0]      idle_nozzle_q, idle_bed_q;
  logic [CountW-1:0]       hotends_q;
  logic                    bed_present_q;

  in_beat_t      in_beat;
  out_beat_t     res;
  out_beat_t     out_beat;
  lane_out_t     lane [NumLanes];
  logic [NumLanes-1:0] lane_hot;
  timer_stat_t   stat;
  logic          in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q        <= '0;
      trigger_q     <= TriggerReset;
      idle_nozzle_q <= '0;
      idle_bed_q    <= '0;
      hotends_q     <= HotendsReset;
      bed_present_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgTimeout:    span_q        <= SpanW'(cfg_data_i[TargetW-1:0]) * MsPerSecond;
        CfgTrigger:    trigger_q     <= cfg_data_i;
        CfgIdleNozzle: idle_nozzle_q <= cfg_data_i[TargetW-1:0];
        CfgIdleBed:    idle_bed_q    <= cfg_data_i[TargetW-1:0];
        CfgHotends:    hotends_q     <= cfg_data_i[CountW-1:0];
        CfgBedPresent: bed_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_beat = in_beat_t'(s_axis_tdata_i);

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    hit_lane u_lane (
      .temp_i        ($signed(in_beat.temp[i])),
      .target_i      (in_beat.target[i]),
      .trigger_i     (trigger_q),
      .idle_target_i (idle_nozzle_q),
      .en_i          ((CountW'(i) < hotends_q) && (i < HotendCount)),
      .lane_o        (lane[i])
    );
    assign lane_hot[i] = lane[i].hot;
  end

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  hit_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .now_i      (in_beat.now_ms),
    .busy_i     (in_beat.busy_req),
    .pos_i      (in_beat.extruder_position),
    .span_i     (span_q),
    .lane_hot_i (lane_hot),
    .stat_o     (stat)
  );

  always_comb begin
    res            = '0;
    res.idle_fired = stat.fire;
    res.armed      = stat.armed;
    for (int i = 0; i < NumLanes; i++) begin
      res.new_target[i] = stat.fire ? lane[i].lowered : in_beat.target[i];
    end
    res.new_bed_target = (stat.fire && bed_present_q && (idle_bed_q < in_beat.bed_target_now))
                         ? idle_bed_q : in_beat.bed_target_now;
  end

  hit_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_beat)
  );

  assign m_axis_tdata_o = OutDataW'(out_beat);

endmodule
